// ----- rtl/core/ihs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihs_pkg
// Shared types, constants and the hash step function of the integer hash set.
// ----------------------------------------------------------------------------
package ihs_pkg;

  localparam int unsigned SLOTS  = 256;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned KEY_W  = 64;

  // hash runs as five shift-add / shift-xor steps
  localparam int unsigned HASH_STEPS = 5;
  localparam int unsigned STEP_W     = $clog2(HASH_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(HASH_STEPS - 1);

  localparam logic [7:0] LOAD_LIMIT_RST = 8'd128;

  // request codes
  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_TEST  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FULL      = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_CLEARED   = 3'd4
  } status_e;

  // one step of the shared hash unit: h + (h << n) or h ^ (h >>> n)
  function automatic logic [KEY_W-1:0] hash_step(input logic [KEY_W-1:0] h,
                                                 input logic [STEP_W-1:0] step);
    logic [5:0]       amt;
    logic             add_op;
    logic [KEY_W-1:0] sh;
    case (step)
      STEP_W'(0): begin amt = 6'd10; add_op = 1'b1; end
      STEP_W'(1): begin amt = 6'd6;  add_op = 1'b0; end
      STEP_W'(2): begin amt = 6'd3;  add_op = 1'b1; end
      STEP_W'(3): begin amt = 6'd11; add_op = 1'b0; end
      STEP_W'(4): begin amt = 6'd15; add_op = 1'b1; end
      default:    begin amt = 6'd0;  add_op = 1'b0; end
    endcase
    sh = add_op ? (h << amt) : KEY_W'($signed(h) >>> amt);
    return add_op ? (h + sh) : (h ^ sh);
  endfunction

endpackage

// ----- rtl/core/ihs_hash_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihs_hash_unit
// Iterative hash: one shift-add or shift-xor step per cycle on a shared unit.
// ----------------------------------------------------------------------------
module ihs_hash_unit
  import ihs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [KEY_W-1:0] key_i,
  output logic             done_o,
  output logic [KEY_W-1:0] hash_o
);

  logic [KEY_W-1:0]  h_q, h_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;

  always_comb begin
    h_d    = h_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      h_d    = key_i;
      step_d = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      h_d = hash_step(h_q, step_q);
      if (step_q == STEP_LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
  end

  assign done_o = done_q;
  assign hash_o = h_q;

endmodule

// ----- rtl/core/ihs_key_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihs_key_ram
// Key storage, one write and one registered read port.
// ----------------------------------------------------------------------------
module ihs_key_ram
  import ihs_pkg::*;
(
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [SLOT_W-1:0] waddr_i,
  input  logic [KEY_W-1:0]  wdata_i,
  input  logic [SLOT_W-1:0] raddr_i,
  output logic [KEY_W-1:0]  rdata_o
);

  logic [KEY_W-1:0] mem [SLOTS];
  logic [KEY_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/integer_hash_set_linear_probe_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_hash_set_linear_probe_unit
// Open-addressing set of 64-bit keys with linear probing.
// ----------------------------------------------------------------------------
// One word in, one word out. An add or a membership test first runs the key
// through a five-step shift-add-xor hash on a shared 64-bit unit (one step a
// cycle), then walks the table from the home slot, one slot per cycle, until
// it hits an empty slot, the key, or has seen every slot. The key memory read
// port sets that probe rate. The input stalls while a request is at work; a
// finished word sits in the output register, so the next request can be
// taken while it waits. Occupancy bits are flip-flops and all clear at once,
// on reset or on a clear request; the key memory itself is never cleared.
// load_limit (reset 128) may be written through the config port at any time
// the unit is idle; adds of new keys are refused as full once the entry count
// reaches it.
// ----------------------------------------------------------------------------
module integer_hash_set_linear_probe_unit
  import ihs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // request channel
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic signed [63:0] key_i,
  // response channel
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        status_o,
  output logic [7:0]        slot_index_o,
  output logic [7:0]        entry_count_o,
  // config channel (load_limit)
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [7:0]        cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_HASH  = 4'b0010,
    S_PROBE = 4'b0100,
    S_RESP  = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [1:0]        req_q, req_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [SLOT_W-1:0] pcnt_q, pcnt_d;
  logic [SLOTS-1:0]  used_q, used_d;
  logic [7:0]        count_q, count_d;
  logic [7:0]        limit_q, limit_d;
  status_e           res_status_q, res_status_d;
  logic [SLOT_W-1:0] res_slot_q, res_slot_d;
  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [7:0]        out_count_q, out_count_d;

  logic              in_accept;
  logic              out_free;
  logic              hash_start;
  logic              hash_done;
  logic [KEY_W-1:0]  hash_val;
  logic              ram_we;
  logic [KEY_W-1:0]  ram_rdata;
  logic              slot_used;
  logic              key_match;

  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign hash_start = in_accept && (req_type_i == REQ_ADD || req_type_i == REQ_TEST);

  ihs_hash_unit u_hash (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(hash_start),
    .key_i  (key_i),
    .done_o (hash_done),
    .hash_o (hash_val)
  );

  // read address follows idx_d, so the data of idx_q is there in S_PROBE
  ihs_key_ram u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(idx_q),
    .wdata_i(key_q),
    .raddr_i(idx_d),
    .rdata_o(ram_rdata)
  );

  assign slot_used = used_q[idx_q];
  assign key_match = (ram_rdata == key_q);

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    key_d        = key_q;
    idx_d        = idx_q;
    pcnt_d       = pcnt_q;
    used_d       = used_q;
    count_d      = count_q;
    limit_d      = limit_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_count_d  = out_count_q;
    ram_we       = 1'b0;

    if (cfg_valid_i) begin
      limit_d = cfg_data_i;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          req_d      = req_type_i;
          key_d      = key_i;
          res_slot_d = '0;
          case (req_type_i)
            REQ_ADD, REQ_TEST: begin
              state_d = S_HASH;
            end
            REQ_CLEAR: begin
              used_d       = '0;
              count_d      = '0;
              res_status_d = ST_CLEARED;
              state_d      = S_RESP;
            end
            default: begin
              res_status_d = ST_NOT_FOUND;
              state_d      = S_RESP;
            end
          endcase
        end
      end
      S_HASH: begin
        if (hash_done) begin
          idx_d   = hash_val[SLOT_W-1:0];
          pcnt_d  = '0;
          state_d = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!slot_used) begin
          // empty slot ends the walk
          state_d = S_RESP;
          if (req_q == REQ_ADD && count_q < limit_q) begin
            ram_we         = 1'b1;
            used_d[idx_q]  = 1'b1;
            count_d        = count_q + 8'd1;
            res_status_d   = ST_INSERTED;
            res_slot_d     = idx_q;
          end else if (req_q == REQ_ADD) begin
            res_status_d = ST_FULL;
          end else begin
            res_status_d = ST_NOT_FOUND;
          end
        end else if (key_match) begin
          res_status_d = ST_PRESENT;
          res_slot_d   = idx_q;
          state_d      = S_RESP;
        end else if (pcnt_q == '1) begin
          // every slot seen, table full
          res_status_d = (req_q == REQ_ADD) ? ST_FULL : ST_NOT_FOUND;
          state_d      = S_RESP;
        end else begin
          idx_d  = idx_q + 1'b1;
          pcnt_d = pcnt_q + 1'b1;
        end
      end
      S_RESP: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_slot_d   = res_slot_q;
          out_count_d  = count_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      count_q     <= '0;
      limit_q     <= LOAD_LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      count_q     <= count_d;
      limit_q     <= limit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    key_q        <= key_d;
    idx_q        <= idx_d;
    pcnt_q       <= pcnt_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_count_q  <= out_count_d;
  end

  assign in_stall_o    = (state_q != S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign slot_index_o  = 8'(out_slot_q);
  assign entry_count_o = out_count_q;

endmodule

// ----- rtl/core/ihs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ihs_checker
// Port-level checks on the integer hash set, bound to the top level.
// ----------------------------------------------------------------------------
module ihs_checker
  import ihs_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [2:0] status_o,
  input logic [7:0] slot_index_o,
  input logic [7:0] entry_count_o
);

  // a held word does not change
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(slot_index_o) && $stable(entry_count_o))
    else $error("response word changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= ST_CLEARED)
    else $error("status code out of range");

  // no slot reported unless found or placed
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_NOT_FOUND
      || status_o == ST_CLEARED) |-> slot_index_o == 8'd0)
    else $error("slot index set on a miss");

  a_clear_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_CLEARED |-> entry_count_o == 8'd0)
    else $error("entry count not zero after clear");

  // a taken request leaves the unit busy in the cycle after it
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("unit not busy after accepting a request");

endmodule

bind integer_hash_set_linear_probe_unit ihs_checker u_ihs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .status_o     (status_o),
  .slot_index_o (slot_index_o),
  .entry_count_o(entry_count_o)
);
